### hdl/matc_pkg.sv
package matc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_W = 32;
	localparam int unsigned CHAN_W = 2;
	localparam int unsigned MASK_W = 4;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd1000;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic clear;
		logic capture;
	} ctrl_t;

endpackage

### hdl/multi_channel_arrival_time_capture.sv
// samples: accepted every cycle, state updated at the accepting edge, no result
// read: first word valid the cycle after acceptance, CHANNELS words at one per cycle
// while out_ready holds; a read is held off while a readout drains, taken as its
// final word is accepted; rate set by the single snapshot buffer in the readout stage
// reset: asynchronous, clears all captured times, flags and ready; timeout_us to 1000
module multi_channel_arrival_time_capture import matc_pkg::*; #(
	parameter int unsigned CHANNELS  = 4,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [MASK_W-1:0]    edge_mask,
	input  logic [TIME_BITS-1:0] now_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAN_W-1:0]    channel,
	output logic [WORD_W-1:0]    time_word,
	output logic                 was_ready,
	output logic                 last
);

	logic [CFG_W-1:0]           timeout_q;
	logic [CHANNELS+MASK_W-1:0] mask_pad;
	logic [TIME_BITS-1:0]       time_q  [CHANNELS];
	logic [TIME_BITS-1:0]       time_nx [CHANNELS];
	logic [CHANNELS-1:0]        flag_nx;
	logic                       room;
	logic                       sample_acc;
	logic                       read_acc;
	logic                       all_q;
	ctrl_t                      ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	assign in_ready = room || (action == ACT_SAMPLE);
	assign sample_acc = in_valid && in_ready && (action == ACT_SAMPLE);
	assign read_acc = in_valid && in_ready && (action == ACT_READ);
	assign mask_pad = (CHANNELS + MASK_W)'(edge_mask);

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		matc_lane #(
			.TIME_BITS(TIME_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.edge_in (mask_pad[g]),
			.now_time(now_time),
			.ctrl    (ctrl),
			.time_q  (time_q[g]),
			.time_nx (time_nx[g]),
			.flag_nx (flag_nx[g])
		);
	end

	matc_merge #(
		.CHANNELS (CHANNELS),
		.TIME_BITS(TIME_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_acc(sample_acc),
		.read_acc  (read_acc),
		.now_time  (now_time),
		.timeout_us(timeout_q),
		.time_nx   (time_nx),
		.flag_nx   (flag_nx),
		.ctrl      (ctrl),
		.all_q     (all_q)
	);

	matc_readout #(
		.CHANNELS (CHANNELS),
		.TIME_BITS(TIME_BITS)
	) u_readout (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (read_acc),
		.times    (time_q),
		.ready_in (all_q),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.channel  (channel),
		.time_word(time_word),
		.was_ready(was_ready),
		.last     (last)
	);

	a_read_gives_words: assert property (@(posedge clk) disable iff (!arst_n)
		read_acc |=> out_valid)
		else $error("no readout after read request");

endmodule

### hdl/matc_lane.sv
module matc_lane import matc_pkg::*; #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 edge_in,
	input  logic [TIME_BITS-1:0] now_time,
	input  ctrl_t                ctrl,
	output logic [TIME_BITS-1:0] time_q,
	output logic [TIME_BITS-1:0] time_nx,
	output logic                 flag_nx
);

	logic flag_q;

	assign time_nx = edge_in ? now_time : time_q;
	assign flag_nx = edge_in | flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			flag_q <= 1'b0;
		end else if (ctrl.clear) begin
			time_q <= '0;
			flag_q <= 1'b0;
		end else if (ctrl.capture) begin
			time_q <= time_nx;
			flag_q <= flag_nx;
		end
	end

endmodule

### hdl/matc_merge.sv
module matc_merge import matc_pkg::*; #(
	parameter int unsigned CHANNELS  = 4,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_acc,
	input  logic                 read_acc,
	input  logic [TIME_BITS-1:0] now_time,
	input  logic [CFG_W-1:0]     timeout_us,
	input  logic [TIME_BITS-1:0] time_nx [CHANNELS],
	input  logic [CHANNELS-1:0]  flag_nx,
	output ctrl_t                ctrl,
	output logic                 all_q
);

	localparam int unsigned LEAF = 1 << $clog2(CHANNELS);
	localparam int unsigned CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	logic [TIME_BITS-1:0] tree [2*LEAF];
	logic [TIME_BITS-1:0] latest;
	logic [TIME_BITS-1:0] age;
	logic                 all_nx;
	logic                 stale;

	always_comb begin
		for (int k = 0; k < 2 * LEAF; k++) begin
			tree[k] = '0;
		end
		for (int k = 0; k < CHANNELS; k++) begin
			tree[LEAF + k] = time_nx[k];
		end
		for (int k = LEAF - 1; k > 0; k--) begin
			tree[k] = (tree[2*k] > tree[2*k+1]) ? tree[2*k] : tree[2*k+1];
		end
	end

	assign latest = tree[(LEAF > 1) ? 1 : LEAF];
	assign age = now_time - latest;
	assign all_nx = &flag_nx;
	assign stale = sample_acc && !all_nx && (|flag_nx) && !all_q &&
		(CMP_W'(age) > CMP_W'(timeout_us)) && (tree[0] == '0 || 1'b1);

	assign ctrl.clear = read_acc | stale;
	assign ctrl.capture = sample_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_q <= 1'b0;
		end else if (read_acc) begin
			all_q <= 1'b0;
		end else if (sample_acc && all_nx) begin
			all_q <= 1'b1;
		end
	end

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		read_acc |=> !all_q)
		else $error("ready flag survived a readout");

	a_all_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_acc && !read_acc && all_nx) |=> all_q)
		else $error("ready flag not set after full capture");

	a_no_stale_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		all_q |-> !stale)
		else $error("timeout discard while ready");

endmodule

### hdl/matc_readout.sv
module matc_readout import matc_pkg::*; #(
	parameter int unsigned CHANNELS  = 4,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [TIME_BITS-1:0] times [CHANNELS],
	input  logic                 ready_in,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAN_W-1:0]    channel,
	output logic [WORD_W-1:0]    time_word,
	output logic                 was_ready,
	output logic                 last
);

	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

	logic [WORD_W-1:0]  snap_q [CHANNELS];
	logic [WORD_W-1:0]  word_nx [CHANNELS];
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W+1:0]   idx_ext;
	logic               busy_q;
	logic               rdy_q;
	logic               take;

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			word_nx[k] = WORD_W'({^times[k][TIME_BITS-2:0], times[k][TIME_BITS-2:0]});
		end
	end

	assign take = busy_q && out_ready;
	assign last = (idx_q == IDX_LAST);
	assign room = !busy_q || (take && last);
	assign out_valid = busy_q;
	assign idx_ext = (IDX_W + 2)'(idx_q);
	assign channel = idx_ext[CHAN_W-1:0];
	assign time_word = snap_q[idx_q];
	assign was_ready = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snap_q <= word_nx;
			rdy_q <= ready_in;
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && idx_q == '0))
		else $error("readout did not start at channel zero");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> room)
		else $error("readout overrun");

endmodule
